// ----- design/crd_pkg.sv -----
// shared types and constants for the camera ray direction block
`timescale 1ns / 1ps
package crd_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int HALF_BITS  = 12;
  localparam int COMP_BITS  = 21;
  localparam int VEC_BITS   = 3 * COMP_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int NORM_BITS  = 30;
  localparam int SUM_BITS   = 2 * NORM_BITS + 2;
  localparam int LEN_BITS   = SUM_BITS / 2;
  localparam int DIR_BITS   = 16;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FORWARD     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UP          = 3'd4;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
    logic                       degenerate;
  } out_item_t;

  // per-ray data handed from the front end through the root pipeline
  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] mag;
    logic [2:0]                neg;
    logic                      degen;
  } ray_side_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] half_width;
    logic [HALF_BITS-1:0] half_height;
    logic [VEC_BITS-1:0]  forward_scaled;
    logic [VEC_BITS-1:0]  right_vector;
    logic [VEC_BITS-1:0]  up_vector;
  } cam_cfg_t;

endpackage

// ----- design/crd_front.sv -----
// front end: offsets, vector build, magnitude normalize and sum of squares
`timescale 1ns / 1ps
module crd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  crd_pkg::in_item_t in_item,
  input  crd_pkg::cam_cfg_t cfg,
  output logic              out_vld,
  output logic [crd_pkg::SUM_BITS-1:0] out_sum,
  output crd_pkg::ray_side_t out_side
);

  localparam int CB = crd_pkg::COMP_BITS;
  localparam int OB = crd_pkg::PIXEL_BITS + 1;
  localparam int PB = CB + OB;
  localparam int VW = PB + 2;
  localparam int NB = crd_pkg::NORM_BITS;
  localparam int BLW = $clog2(VW + 1);
  localparam int NST = 8;

  function automatic logic [BLW-1:0] bit_len(input logic [VW-1:0] x);
    logic [BLW-1:0] n;
    n = '0;
    for (int i = 0; i < VW; i++) begin
      if (x[i]) n = BLW'(i + 1);
    end
    return n;
  endfunction

  logic [NST-1:0] vld_r;

  logic signed [CB-1:0] f_r [3];
  logic signed [PB-1:0] p_r [3];
  logic signed [PB-1:0] q_r [3];
  logic signed [VW-1:0] v_r [3];
  logic [VW-1:0]        m3_r [3];
  logic [VW-1:0]        m4_r [3];
  logic [VW-1:0]        max_r;
  logic [VW-1:0]        m5_r [3];
  logic [BLW-1:0]       bl_r;
  logic [NB-1:0]        m6_r [3];
  logic [NB-1:0]        m7_r [3];
  logic [2*NB-1:0]      sq_r [3];
  logic [NB-1:0]        m8_r [3];
  logic [crd_pkg::SUM_BITS-1:0] sum_r;
  logic [2:0]           neg3_r, neg4_r, neg5_r, neg6_r, neg7_r, neg8_r;
  logic                 z5_r, z6_r, z7_r, z8_r;

  logic signed [OB-1:0] xoff, yoff;
  logic [VW-1:0]        max_nxt;

  // pixel offsets from the image center
  assign xoff = $signed({1'b0, in_item.pixel_x}) - $signed({1'b0, cfg.half_width});
  assign yoff = $signed({1'b0, in_item.pixel_y}) - $signed({1'b0, cfg.half_height});

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      f_r[k] <= $signed(cfg.forward_scaled[k*CB +: CB]);
      p_r[k] <= $signed(cfg.right_vector[k*CB +: CB]) * xoff;
      q_r[k] <= $signed(cfg.up_vector[k*CB +: CB]) * yoff;
    end
  end

  // stage 2: v = f*2048 - r*xoff + u*yoff
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      v_r[k] <= (VW'(f_r[k]) <<< 11) - VW'(p_r[k]) + VW'(q_r[k]);
    end
  end

  // stage 3: magnitudes and signs
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m3_r[k]   <= v_r[k][VW-1] ? VW'(-v_r[k]) : VW'(v_r[k]);
      neg3_r[k] <= v_r[k][VW-1];
    end
  end

  // stage 4: largest magnitude
  always_comb begin
    max_nxt = m3_r[0];
    if (m3_r[1] > max_nxt) max_nxt = m3_r[1];
    if (m3_r[2] > max_nxt) max_nxt = m3_r[2];
  end

  always_ff @(posedge clk) begin
    m4_r   <= m3_r;
    max_r  <= max_nxt;
    neg4_r <= neg3_r;
  end

  // stage 5: bit length of the largest magnitude
  always_ff @(posedge clk) begin
    m5_r   <= m4_r;
    bl_r   <= bit_len(max_r);
    z5_r   <= (max_r == '0);
    neg5_r <= neg4_r;
  end

  // stage 6: shift so the largest has its top bit at NB-1
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (bl_r > BLW'(NB)) begin
        m6_r[k] <= NB'(m5_r[k] >> (bl_r - BLW'(NB)));
      end else begin
        m6_r[k] <= NB'(m5_r[k] << (BLW'(NB) - bl_r));
      end
    end
    z6_r   <= z5_r;
    neg6_r <= neg5_r;
  end

  // stage 7: squares
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= m6_r[k] * m6_r[k];
    end
    m7_r   <= m6_r;
    z7_r   <= z6_r;
    neg7_r <= neg6_r;
  end

  // stage 8: sum of squares
  always_ff @(posedge clk) begin
    sum_r  <= crd_pkg::SUM_BITS'(sq_r[0]) + crd_pkg::SUM_BITS'(sq_r[1])
            + crd_pkg::SUM_BITS'(sq_r[2]);
    m8_r   <= m7_r;
    z8_r   <= z7_r;
    neg8_r <= neg7_r;
  end

  assign out_vld        = vld_r[NST-1];
  assign out_sum        = sum_r;
  assign out_side.mag   = {m8_r[2], m8_r[1], m8_r[0]};
  assign out_side.neg   = neg8_r;
  assign out_side.degen = z8_r;

endmodule

// ----- design/crd_sqrt.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module crd_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [crd_pkg::SUM_BITS-1:0] in_sum,
  input  crd_pkg::ray_side_t in_side,
  output logic              out_vld,
  output logic [crd_pkg::LEN_BITS-1:0] out_len,
  output crd_pkg::ray_side_t out_side
);

  localparam int SW = crd_pkg::SUM_BITS;
  localparam int NS = crd_pkg::LEN_BITS;
  localparam int RW = NS + 3;

  logic [NS:0]         vld_r;
  logic [SW-1:0]       x_r   [NS+1];
  logic [RW-1:0]       rem_r [NS+1];
  logic [NS-1:0]       root_r [NS+1];
  crd_pkg::ray_side_t  side_r [NS+1];

  // stage 0 holds the operand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= in_sum;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  // each stage brings in two operand bits and decides one root bit
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    logic [RW-1:0] rem_in, trial;

    assign rem_in = {rem_r[s-1][RW-3:0], x_r[s-1][SW-1 -: 2]};
    assign trial  = RW'({root_r[s-1], 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      x_r[s]    <= x_r[s-1] << 2;
      side_r[s] <= side_r[s-1];
      if (rem_in >= trial) begin
        rem_r[s]  <= rem_in - trial;
        root_r[s] <= {root_r[s-1][NS-2:0], 1'b1};
      end else begin
        rem_r[s]  <= rem_in;
        root_r[s] <= {root_r[s-1][NS-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_len  = root_r[NS];
  assign out_side = side_r[NS];

endmodule

// ----- design/crd_div.sv -----
// pipelined rounded divide of each magnitude by the length, one quotient bit per stage
`timescale 1ns / 1ps
module crd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [crd_pkg::LEN_BITS-1:0] in_len,
  input  crd_pkg::ray_side_t in_side,
  output logic              out_vld,
  output crd_pkg::out_item_t out_item
);

  localparam int NB = crd_pkg::NORM_BITS;
  localparam int LB = crd_pkg::LEN_BITS;
  localparam int QB = crd_pkg::DIR_BITS;
  localparam int NW = NB + QB + 1;
  localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_MAX = {1'b1, {(QB-1){1'b0}}};

  logic [QB:0]          vld_r;
  logic [NW-1:0]        num_r [QB+1][3];
  logic [QB-1:0]        quo_r [QB+1][3];
  logic [LB-1:0]        den_r [QB+1];
  logic [2:0]           neg_r [QB+1];
  logic                 dg_r  [QB+1];
  logic                 ovld_r;
  crd_pkg::out_item_t   oitem_r;
  logic [QB-1:0]        dir_nxt [3];

  // valid bits, the output strobe included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[QB-1:0], in_vld};
      ovld_r <= vld_r[QB];
    end
  end

  // stage 0: numerator m*2^15 + len/2
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num_r[0][k] <= NW'({in_side.mag[k], {(QB-1){1'b0}}}) + NW'(in_len >> 1);
      quo_r[0][k] <= '0;
    end
    den_r[0] <= in_len;
    neg_r[0] <= in_side.neg;
    dg_r[0]  <= in_side.degen;
  end

  // restoring divide, most significant quotient bit first
  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int B = QB - s;
    logic [NW-1:0] sub;
    assign sub = NW'(den_r[s-1]) << B;

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (num_r[s-1][k] >= sub) begin
          num_r[s][k] <= num_r[s-1][k] - sub;
          quo_r[s][k] <= quo_r[s-1][k] | (QB'(1) << B);
        end else begin
          num_r[s][k] <= num_r[s-1][k];
          quo_r[s][k] <= quo_r[s-1][k];
        end
      end
      den_r[s] <= den_r[s-1];
      neg_r[s] <= neg_r[s-1];
      dg_r[s]  <= dg_r[s-1];
    end
  end

  // zero degenerate rays, else saturate and apply the sign
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dg_r[QB]) begin
        dir_nxt[k] = '0;
      end else if (neg_r[QB][k]) begin
        dir_nxt[k] = (quo_r[QB][k] > NEG_MAX) ? NEG_MAX : QB'(-quo_r[QB][k]);
      end else begin
        dir_nxt[k] = (quo_r[QB][k] > POS_MAX) ? POS_MAX : quo_r[QB][k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    oitem_r.dir_x      <= $signed(dir_nxt[0]);
    oitem_r.dir_y      <= $signed(dir_nxt[1]);
    oitem_r.dir_z      <= $signed(dir_nxt[2]);
    oitem_r.degenerate <= dg_r[QB];
  end

  assign out_vld  = ovld_r;
  assign out_item = oitem_r;

endmodule

// ----- design/camera_ray_direction.sv -----
// top level of the pinhole camera primary ray direction generator
`timescale 1ns / 1ps
// Usage:
//  Input channel: drive in_item (pixel_x, pixel_y) with start high; a
//  transaction is taken at each rising edge where start is high and busy is
//  low. busy is a register set only by reset, so one pixel a cycle is taken.
//  Result channel: out_valid strobes for one cycle with out_item holding
//  dir_x, dir_y, dir_z (Q1.15 unit direction) and degenerate.
//  Each accepted pixel passes in order through the 8-stage front end, the
//  32-stage square root (operand register plus one root bit per stage) and
//  the 18-stage divider (one quotient bit per stage plus round and output)
//  before the strobe.
//  Throughput is one transaction per cycle; the receiver cannot stall, and
//  results appear in acceptance order.
//  Configuration: cfg_valid/cfg_ready write cfg_data into register
//  cfg_index (0 half_width, 1 half_height, 2 forward_scaled, 3 right_vector,
//  4 up_vector); other indexes are ignored. cfg_ready is always high.
//  Write registers only while no ray is in flight.
//  Reset (synchronous, active low) clears all valid bits and loads
//  half_width 320, half_height 240 and zero vectors.
module camera_ray_direction (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  crd_pkg::in_item_t   in_item,
  output logic                out_valid,
  output crd_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [crd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [crd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int LAT = 8 + (crd_pkg::LEN_BITS + 1) + crd_pkg::DIR_BITS + 2;

  crd_pkg::cam_cfg_t  cfg_r;
  logic               busy_r;
  logic               acc;
  logic               f_vld, s_vld;
  logic [crd_pkg::SUM_BITS-1:0] f_sum;
  logic [crd_pkg::LEN_BITS-1:0] s_len;
  crd_pkg::ray_side_t f_side, s_side;

  assign acc       = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // busy is set only by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width     <= crd_pkg::HALF_BITS'(320);
      cfg_r.half_height    <= crd_pkg::HALF_BITS'(240);
      cfg_r.forward_scaled <= '0;
      cfg_r.right_vector   <= '0;
      cfg_r.up_vector      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        crd_pkg::REG_HALF_WIDTH:
          cfg_r.half_width <= cfg_data[crd_pkg::HALF_BITS-1:0];
        crd_pkg::REG_HALF_HEIGHT:
          cfg_r.half_height <= cfg_data[crd_pkg::HALF_BITS-1:0];
        crd_pkg::REG_FORWARD:
          cfg_r.forward_scaled <= cfg_data[crd_pkg::VEC_BITS-1:0];
        crd_pkg::REG_RIGHT:
          cfg_r.right_vector <= cfg_data[crd_pkg::VEC_BITS-1:0];
        crd_pkg::REG_UP:
          cfg_r.up_vector <= cfg_data[crd_pkg::VEC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  crd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_item (in_item),
    .cfg     (cfg_r),
    .out_vld (f_vld),
    .out_sum (f_sum),
    .out_side(f_side)
  );

  crd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .in_sum  (f_sum),
    .in_side (f_side),
    .out_vld (s_vld),
    .out_len (s_len),
    .out_side(s_side)
  );

  crd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s_vld),
    .in_len  (s_len),
    .in_side (s_side),
    .out_vld (out_valid),
    .out_item(out_item)
  );

  // every result comes from an earlier accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result without matching transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc, LAT) && $past(rst_n, LAT) |-> out_valid)
    else $error("transaction lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |->
      out_item.dir_x == '0 && out_item.dir_y == '0 && out_item.dir_z == '0)
    else $error("degenerate ray with nonzero direction");

  // a unit vector has some component of at least one half
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.degenerate |->
      !(out_item.dir_x > -16'sd16384 && out_item.dir_x < 16'sd16384 &&
        out_item.dir_y > -16'sd16384 && out_item.dir_y < 16'sd16384 &&
        out_item.dir_z > -16'sd16384 && out_item.dir_z < 16'sd16384))
    else $error("direction far from unit length");

endmodule

// ----- dv/tb_camera_ray_direction.sv -----
// testbench for the camera ray direction block: random pixels and camera setups checked against a predictor
`timescale 1ns / 1ps
module tb_camera_ray_direction;

  localparam logic [crd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int PIPE_CYCLES = 64;

  // expected rays and the camera setup they are computed from
  class ray_scoreboard;
    crd_pkg::out_item_t dir_q[$];
    logic [11:0]       half_w, half_h;
    logic [crd_pkg::VEC_BITS-1:0] fwd, rgt, upv;
    int                mismatches;
    int                rays_checked;
    int                degen_seen;

    function void reset_regs();
      half_w = 12'd320;
      half_h = 12'd240;
      fwd = '0;
      rgt = '0;
      upv = '0;
    endfunction

    function void write_reg(logic [crd_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [crd_pkg::CFG_DATA_BITS-1:0] d);
      case (idx)
        crd_pkg::REG_HALF_WIDTH:  half_w = d[11:0];
        crd_pkg::REG_HALF_HEIGHT: half_h = d[11:0];
        crd_pkg::REG_FORWARD:     fwd = d[crd_pkg::VEC_BITS-1:0];
        crd_pkg::REG_RIGHT:       rgt = d[crd_pkg::VEC_BITS-1:0];
        crd_pkg::REG_UP:          upv = d[crd_pkg::VEC_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint comp(logic [crd_pkg::VEC_BITS-1:0] p, int k);
      logic signed [crd_pkg::COMP_BITS-1:0] c;
      c = p[k*crd_pkg::COMP_BITS +: crd_pkg::COMP_BITS];
      return longint'(c);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // unnormalized direction, common exponent, then divide by the length
    function crd_pkg::out_item_t ray_dir(crd_pkg::in_item_t it);
      longint xo, yo;
      longint v[3];
      longint unsigned m[3];
      longint unsigned maxm, sum, len, q, t;
      logic [15:0] d[3];
      int bl;
      crd_pkg::out_item_t r;
      xo = longint'(it.pixel_x) - longint'(half_w);
      yo = longint'(it.pixel_y) - longint'(half_h);
      maxm = 0;
      for (int k = 0; k < 3; k++) begin
        v[k] = comp(fwd, k) * 2048 - comp(rgt, k) * xo + comp(upv, k) * yo;
        m[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
        if (m[k] > maxm) maxm = m[k];
      end
      r = '0;
      if (maxm == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      bl = 0;
      t = maxm;
      while (t != 0) begin
        bl++;
        t = t >> 1;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        if (bl > crd_pkg::NORM_BITS) m[k] = m[k] >> (bl - crd_pkg::NORM_BITS);
        else m[k] = m[k] << (crd_pkg::NORM_BITS - bl);
        sum += m[k] * m[k];
      end
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
        q = ((m[k] << 15) + (len >> 1)) / len;
        if (v[k] < 0) begin
          if (q > 32768) q = 32768;
          d[k] = 16'(64'd0 - q);
        end else begin
          if (q > 32767) q = 32767;
          d[k] = q[15:0];
        end
      end
      r.dir_x = d[0];
      r.dir_y = d[1];
      r.dir_z = d[2];
      return r;
    endfunction

    function void note_ray(crd_pkg::in_item_t it);
      dir_q.push_back(ray_dir(it));
    endfunction

    function void check_ray(crd_pkg::out_item_t got);
      crd_pkg::out_item_t want;
      if (dir_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected ray result %p", got);
        mismatches++;
        return;
      end
      want = dir_q.pop_front();
      rays_checked++;
      if (got.degenerate) degen_seen++;
      if (got.dir_x !== want.dir_x || got.dir_y !== want.dir_y ||
          got.dir_z !== want.dir_z || got.degenerate !== want.degenerate) begin
        if (mismatches < 10)
          $display("ray mismatch: expected %p got %p", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  crd_pkg::in_item_t in_item = '0;
  logic out_valid;
  crd_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [crd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [crd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  ray_scoreboard sb = new();
  bit no_idle = 1'b0;
  int rays_sent = 0;
  int cfg_writes = 0;

  camera_ray_direction DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_ray(out_item);
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic write_reg(logic [crd_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [crd_pkg::CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one pixel transaction, with occasional idle cycles before it unless no_idle is set
  task automatic send_ray(logic [11:0] px, logic [11:0] py);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 8) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_item.pixel_x = px;
    in_item.pixel_y = py;
    do @(posedge clk); while (busy);
    sb.note_ray(in_item);
    rays_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.dir_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [20:0] rand_comp();
    case ($urandom_range(5))
      0: return 21'h100000;
      1: return 21'h0fffff;
      2: return 21'd0;
      3: return 21'(int'($urandom_range(2000)) - 1000);
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_vec();
    return {1'($urandom), rand_comp(), rand_comp(), rand_comp()};
  endfunction

  function automatic logic [63:0] rand_half();
    case ($urandom_range(3))
      0: return 64'd0;
      1: return 64'hffff_ffff_ffff_ffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [11:0] rand_pix();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    sb.reset_regs();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setup: zero vectors, every ray is degenerate
    send_ray(12'd0, 12'd0);
    send_ray(12'hfff, 12'hfff);
    send_ray(12'd320, 12'd240);
    drain();

    // axis-aligned camera: centre pixel gives a zero vector, edges give extremes
    write_reg(crd_pkg::REG_FORWARD, 64'd0);
    write_reg(crd_pkg::REG_RIGHT, 64'd1 << 19);
    write_reg(crd_pkg::REG_UP, 64'd1 << 40);
    write_reg(REG_UNUSED, 64'hdead_beef);
    send_ray(12'd320, 12'd240);
    send_ray(12'd0, 12'd240);
    send_ray(12'hfff, 12'd240);
    send_ray(12'd320, 12'd0);
    send_ray(12'd320, 12'hfff);
    send_ray(12'd0, 12'hfff);
    drain();

    // strongest components of both signs, half sizes at the extremes
    write_reg(crd_pkg::REG_HALF_WIDTH, 64'hfff);
    write_reg(crd_pkg::REG_HALF_HEIGHT, 64'd0);
    write_reg(crd_pkg::REG_FORWARD, {1'b1, 21'h100000, 21'h0fffff, 21'h100000});
    write_reg(crd_pkg::REG_RIGHT, {1'b0, 21'h0fffff, 21'h100000, 21'h0fffff});
    write_reg(crd_pkg::REG_UP, {1'b1, 21'h100000, 21'h100000, 21'h0fffff});
    send_ray(12'd0, 12'd0);
    send_ray(12'hfff, 12'hfff);
    send_ray(12'h800, 12'h7ff);
    send_ray(12'd0, 12'hfff);
    drain();

    // realistic 640x480 camera looking down z
    write_reg(crd_pkg::REG_HALF_WIDTH, 64'd320);
    write_reg(crd_pkg::REG_HALF_HEIGHT, 64'd240);
    write_reg(crd_pkg::REG_FORWARD, {1'b0, 21'(554 * 256), 21'd0, 21'd0});
    write_reg(crd_pkg::REG_RIGHT, {22'd0, 21'd0, 21'd1 << 19});
    write_reg(crd_pkg::REG_UP, {1'b0, 21'd0, 21'd1 << 19, 21'd0});
    for (int i = 0; i < 150; i++) send_ray(12'($urandom_range(639)), 12'($urandom_range(479)));
    drain();

    // random setups; one phase runs with no idle cycles
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      write_reg(crd_pkg::REG_HALF_WIDTH, rand_half());
      write_reg(crd_pkg::REG_HALF_HEIGHT, rand_half());
      write_reg(crd_pkg::REG_FORWARD, rand_vec());
      write_reg(crd_pkg::REG_RIGHT, rand_vec());
      write_reg(crd_pkg::REG_UP, rand_vec());
      for (int i = 0; i < 190; i++) begin
        send_ray(rand_pix(), rand_pix());
        // hold off until the pipeline is empty once per phase
        if (i == 95) drain();
      end
      drain();
    end

    $display("%0d rays checked over %0d register writes, %0d degenerate",
             sb.rays_checked, cfg_writes, sb.degen_seen);
    if (sb.mismatches == 0 && sb.dir_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
